// ----- rtl/core/bcgd_pkg.sv -----
package bcgd_pkg;

    // Event codes carried on the result channel
    localparam logic [2:0] EV_PRESSED    = 3'd0;
    localparam logic [2:0] EV_RELEASED   = 3'd1;
    localparam logic [2:0] EV_LONG_START = 3'd2;
    localparam logic [2:0] EV_LONG_STOP  = 3'd3;
    localparam logic [2:0] EV_CLICK      = 3'd4;
    localparam logic [2:0] EV_DOUBLE     = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEBOUNCE_TIME  = 3'd0;
    localparam logic [2:0] CFG_CLICK_MAX_TIME = 3'd1;
    localparam logic [2:0] CFG_LONG_PRESS     = 3'd2;
    localparam logic [2:0] CFG_DOUBLE_WINDOW  = 3'd3;
    localparam logic [2:0] CFG_TICK_PERIOD    = 3'd4;
    localparam logic [2:0] CFG_ACTIVE_LEVEL   = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TIMER_W     = 17;

    typedef logic [2:0]         t_code;
    typedef logic [TIMER_W-1:0] t_timer;

    // One tick's worth of events: one or two codes
    typedef struct packed {
        logic  two;
        t_code code0;
        t_code code1;
    } t_evt_pair;

endpackage

// ----- rtl/core/bcgd_front.sv -----
module bcgd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_raw_level,
    input  logic                               i_cfg_valid,
    input  logic [bcgd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bcgd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_q_full,
    output logic                               o_push,
    output bcgd_pkg::t_evt_pair                o_pair
);
    import bcgd_pkg::*;

    logic [15:0] r_debounce_time, r_click_max, r_long_press, r_dbl_window;
    logic [7:0]  r_tick_period;
    logic        r_active_level;

    logic   r_prev, r_stable, r_press, r_long, r_await;
    t_timer r_deb, r_ptimer, r_cwt;
    logic   n_prev, n_stable, n_press, n_long, n_await;
    t_timer n_deb, n_ptimer, n_cwt;

    logic [1:0] cnt;
    t_code      c0, c1;
    logic       accept;

    function automatic t_timer sat_add(input t_timer t, input logic [7:0] inc);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + {{(TIMER_W-7){1'b0}}, inc};
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_prev   = r_prev;
        n_stable = r_stable;
        n_press  = r_press;
        n_long   = r_long;
        n_await  = r_await;
        n_deb    = r_deb;
        n_ptimer = r_ptimer;
        n_cwt    = r_cwt;
        cnt      = 2'd0;
        c0       = EV_PRESSED;
        c1       = EV_PRESSED;

        // Debounce and classify the stable edge
        if (i_raw_level != r_prev) begin
            n_prev = i_raw_level;
            n_deb  = '0;
        end else if (r_deb < {1'b0, r_debounce_time}) begin
            n_deb = sat_add(r_deb, r_tick_period);
        end else if (r_stable != i_raw_level) begin
            n_stable = i_raw_level;
            n_press  = (i_raw_level == r_active_level);
            if (n_press) begin
                n_ptimer = '0;
                n_long   = 1'b0;
                c0       = EV_PRESSED;
                cnt      = 2'd1;
            end else begin
                c0  = EV_RELEASED;
                cnt = 2'd1;
                if (r_long) begin
                    c1      = EV_LONG_STOP;
                    cnt     = 2'd2;
                    n_await = 1'b0;
                end else if (r_ptimer <= {1'b0, r_click_max}) begin
                    if (r_await) begin
                        c1      = EV_DOUBLE;
                        cnt     = 2'd2;
                        n_await = 1'b0;
                    end else begin
                        n_await = 1'b1;
                        n_cwt   = '0;
                    end
                end
            end
        end

        // Advance the press and click-wait timers
        if (n_press) begin
            n_ptimer = sat_add(n_ptimer, r_tick_period);
            if (!n_long && n_ptimer >= {1'b0, r_long_press}) begin
                n_long  = 1'b1;
                n_await = 1'b0;
                if (cnt == 2'd0) begin
                    c0  = EV_LONG_START;
                    cnt = 2'd1;
                end else if (cnt == 2'd1) begin
                    c1  = EV_LONG_START;
                    cnt = 2'd2;
                end
            end
        end else if (n_await) begin
            n_cwt = sat_add(n_cwt, r_tick_period);
            if (n_cwt >= {1'b0, r_dbl_window}) begin
                n_await = 1'b0;
                if (cnt == 2'd0) begin
                    c0  = EV_CLICK;
                    cnt = 2'd1;
                end else if (cnt == 2'd1) begin
                    c1  = EV_CLICK;
                    cnt = 2'd2;
                end
            end
        end
    end

    assign o_push       = accept && (cnt != 2'd0);
    assign o_pair.two   = (cnt == 2'd2);
    assign o_pair.code0 = c0;
    assign o_pair.code1 = c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= 16'd30;
            r_click_max     <= 16'd400;
            r_long_press    <= 16'd1000;
            r_dbl_window    <= 16'd450;
            r_tick_period   <= 8'd5;
            r_active_level  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TIME:  r_debounce_time <= i_cfg_data;
                CFG_CLICK_MAX_TIME: r_click_max     <= i_cfg_data;
                CFG_LONG_PRESS:     r_long_press    <= i_cfg_data;
                CFG_DOUBLE_WINDOW:  r_dbl_window    <= i_cfg_data;
                CFG_TICK_PERIOD:    r_tick_period   <= i_cfg_data[7:0];
                CFG_ACTIVE_LEVEL:   r_active_level  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_stable <= 1'b1;
            r_press  <= 1'b0;
            r_long   <= 1'b0;
            r_await  <= 1'b0;
            r_deb    <= '0;
            r_ptimer <= '0;
            r_cwt    <= '0;
        end else if (accept) begin
            r_prev   <= n_prev;
            r_stable <= n_stable;
            r_press  <= n_press;
            r_long   <= n_long;
            r_await  <= n_await;
            r_deb    <= n_deb;
            r_ptimer <= n_ptimer;
            r_cwt    <= n_cwt;
        end
    end

endmodule

// ----- rtl/core/bcgd_queue.sv -----
module bcgd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bcgd_pkg::t_evt_pair i_pair,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output bcgd_pkg::t_evt_pair o_pair
);
    import bcgd_pkg::*;

    t_evt_pair  r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_pair  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wptr <= ~r_wptr;
            if (do_pop)  r_rptr <= ~r_rptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/bcgd_back.sv -----
module bcgd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  bcgd_pkg::t_evt_pair i_pair,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_event_code,
    output logic                o_last_event
);
    import bcgd_pkg::*;

    t_evt_pair r_pair;
    logic      r_valid, r_sel;
    logic      last, xfer;

    assign last         = r_sel || !r_pair.two;
    assign xfer         = r_valid && i_ready;
    assign o_pop        = !i_q_empty && (!r_valid || (xfer && last));
    assign o_valid      = r_valid;
    assign o_event_code = r_sel ? r_pair.code1 : r_pair.code0;
    assign o_last_event = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pair <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (xfer) begin
            if (last) begin
                r_valid <= 1'b0;
                r_sel   <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/button_click_gesture_detector_top.sv -----
// Button gesture detector. Each input transfer is one poll tick carrying the
// sampled pin level; the level is debounced against debounce_time and the
// stable level is classified into pressed, released, long-press start and
// stop, click and double-click events, each leaving as one output transfer
// with last_event marking the final event of its tick. A tick is accepted in
// the same cycle it is offered whenever the two-entry event queue has room,
// so ticks can arrive back to back; ticks that produce no event never touch
// the queue. The output stage drains one event per cycle while i_ready is
// high; a tick's first event passes the queue write and then the output
// register before it appears. Configuration writes are taken every cycle
// (o_cfg_ready is tied high) and must only be issued while the block is
// idle; indexes above 5 are ignored. All timers are 17 bits and saturate
// rather than wrap.
module button_click_gesture_detector_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_raw_level,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_event_code,
    output logic                             o_last_event,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bcgd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bcgd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bcgd_pkg::*;

    logic      q_full, q_empty, push, pop;
    t_evt_pair push_pair, head_pair;

    assign o_cfg_ready = 1'b1;

    // Front: hold config, debounce and classify each tick
    bcgd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_raw_level (i_raw_level),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_pair      (push_pair)
    );

    // Queue: decouple ticks from the output side
    bcgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_pair  (head_pair)
    );

    // Back: drain one event per transfer
    bcgd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_pair       (head_pair),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_code (o_event_code),
        .o_last_event (o_last_event)
    );

endmodule
